FILE: design/kvpd_pkg.sv
package kvpd_pkg;

    localparam int MaxFields   = 128;
    localparam int MaxKeyBytes = 128;
    localparam int SlotBits    = $clog2(MaxFields);
    localparam int PosBits     = $clog2(MaxKeyBytes);

    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_TOO_LRG  = 3'd2;
    localparam logic [2:0] ST_BAD_ENT  = 3'd3;
    localparam logic [2:0] ST_BAD_KEY  = 3'd4;
    localparam logic [2:0] ST_BAD_ESC  = 3'd5;
    localparam logic [2:0] ST_LIMIT    = 3'd6;
    localparam logic [2:0] ST_DUP      = 3'd7;

    localparam logic REG_MAX_MSG = 1'b0;
    localparam logic REG_MAX_VAL = 1'b1;

    typedef struct packed {
        logic                cur_we;
        logic                store_we;
        logic [SlotBits-1:0] w_slot;
        logic [PosBits-1:0]  w_pos;
        logic [7:0]          w_byte;
        logic                len_we;
        logic [7:0]          len_wdata;
        logic [SlotBits-1:0] r_slot;
        logic [PosBits-1:0]  r_pos;
    } t_kmem_req;

    typedef struct packed {
        logic [7:0] len;
        logic [7:0] store_byte;
        logic [7:0] cur_byte;
    } t_kmem_rsp;

    typedef struct packed {
        logic [16:0] max_msg;
        logic [15:0] max_val;
    } t_cfg;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        logic [7:0] t;
        if (b >= "0" && b <= "9") t = b - 8'h30;
        else if (b >= "a" && b <= "f") t = b - 8'h57;
        else t = b - 8'h37;
        return t[3:0];
    endfunction

    function automatic logic key_char_ok(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "0" && b <= "9") ||
               b == "_" || b == "-" || b == ".";
    endfunction

endpackage

FILE: design/kvpd_cfg.sv
module kvpd_cfg import kvpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);
    logic [16:0] r_max_msg;
    logic [15:0] r_max_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_msg <= 17'd65536;
            r_max_val <= 16'd32768;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_MAX_MSG) r_max_msg <= pwdata[16:0];
            else r_max_val <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_MSG) ? {15'd0, r_max_msg} : {16'd0, r_max_val};
    assign o_cfg  = '{max_msg: r_max_msg, max_val: r_max_val};
endmodule

FILE: design/kvpd_key_mem.sv
module kvpd_key_mem import kvpd_pkg::*; (
    input  logic      i_clk,
    input  t_kmem_req i_req,
    output t_kmem_rsp o_rsp
);
    logic [7:0] r_store [MaxFields*MaxKeyBytes];
    logic [7:0] r_cur   [MaxKeyBytes];
    logic [7:0] r_lens  [MaxFields];
    logic [7:0] r_len_q, r_store_q, r_cur_q;

    always_ff @(posedge i_clk) begin
        if (i_req.store_we) r_store[{i_req.w_slot, i_req.w_pos}] <= i_req.w_byte;
        r_store_q <= r_store[{i_req.r_slot, i_req.r_pos}];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.cur_we) r_cur[i_req.w_pos] <= i_req.w_byte;
        r_cur_q <= r_cur[i_req.r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.len_we) r_lens[i_req.w_slot] <= i_req.len_wdata;
        r_len_q <= r_lens[i_req.r_slot];
    end

    assign o_rsp = '{len: r_len_q, store_byte: r_store_q, cur_byte: r_cur_q};
endmodule

FILE: design/key_value_payload_decoder_unit.sv
// key=value message parser, one raw byte per input word. a key byte or a decoded value
// byte is registered and appears in the cycle after it is taken; '%' escape bytes, the
// '=' that ends a key and ';' give no word. at each ';' and at end of message the entry
// is checked, and when the earlier checks pass its key is compared against the stored
// keys until a duplicate is found, one stored length or one byte at a time through the
// key memory read ports. the input is not ready while an entry end is checked; ordinary
// bytes are taken whenever the output slot is free.
// the final status word closes the message and waits for a free output slot; on a
// nonzero status the consumer drops the bytes of that message.
module key_value_payload_decoder_unit import kvpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [6:0]  o_field_number,
    output logic [2:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CHK  = 7'b0000010,
        S_LEN  = 7'b0000100,
        S_LCHK = 7'b0001000,
        S_BYTE = 7'b0010000,
        S_BCHK = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_cfg      cfg;
    t_kmem_req kreq;
    t_kmem_rsp krsp;

    kvpd_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_cfg(cfg)
    );

    kvpd_key_mem u_mem (.i_clk, .i_req(kreq), .o_rsp(krsp));

    t_state      r_state, n_state;
    logic        r_end, n_end;
    logic [8:0]  r_count, n_count;
    logic [17:0] r_msg_len, n_msg_len;
    logic        r_phase, n_phase;
    logic [1:0]  r_esc_step, n_esc_step;
    logic [3:0]  r_esc_hi, n_esc_hi;
    logic [7:0]  r_key_len, n_key_len;
    logic [16:0] r_val_len, n_val_len;
    logic [7:0]  r_last, n_last;
    logic [5:0]  r_flags, n_flags;
    logic [2:0]  r_first, n_first;
    logic [1:0]  r_raw_len, n_raw_len;
    logic [7:0]  r_index, n_index;
    logic [17:0] r_val_esc, n_val_esc;
    logic [16:0] r_enc, n_enc;
    logic [2:0]  r_code, n_code;
    logic [8:0]  r_i, n_i;
    logic [7:0]  r_j, n_j;
    logic        r_o_valid, n_o_valid;
    logic [1:0]  r_o_kind, n_o_kind;
    logic [7:0]  r_o_byte, n_o_byte;
    logic [6:0]  r_o_field, n_o_field;
    logic [2:0]  r_o_status, n_o_status;

    // flag bits
    localparam int FCrlf = 0, FEqFirst = 1, FKeyChar = 2, FKeyDot = 3, FValEq = 4, FEsc = 5;

    logic        slot_free, take;
    logic [2:0]  pre_code, fin_code, fe;
    logic [18:0] added;
    logic [19:0] enc_sum;
    logic [7:0]  vb;
    logic        emit_v;
    logic [18:0] esc_sum;

    assign slot_free = !r_o_valid || i_ready;
    assign o_ready   = (r_state == S_IDLE) && slot_free;
    assign take      = i_valid && o_ready;

    always_comb begin
        pre_code = ST_OK;
        if (r_raw_len == 2'd0 || r_flags[FCrlf] || !r_phase || r_flags[FEqFirst])
            pre_code = ST_BAD_ENT;
        else if (r_flags[FKeyChar] || r_flags[FKeyDot] || r_last == ".")
            pre_code = ST_BAD_KEY;
        else if (r_flags[FValEq])
            pre_code = ST_BAD_ENT;
        else if (r_flags[FEsc] || r_esc_step != 2'd0)
            pre_code = ST_BAD_ESC;
        else if (r_key_len > 8'(MaxKeyBytes) || r_val_len > {1'b0, cfg.max_val})
            pre_code = ST_LIMIT;
    end

    assign added   = 19'(r_count != 9'd0) + 19'(r_key_len) + 19'd1 + 19'(r_val_esc);
    assign enc_sum = 20'(r_enc) + 20'(added);

    always_comb begin
        fin_code = r_code;
        if (r_code == ST_OK) begin
            if (r_count >= 9'(MaxFields)) fin_code = ST_LIMIT;
            else if (r_enc > cfg.max_msg || enc_sum > 20'(cfg.max_msg)) fin_code = ST_LIMIT;
        end
    end
    assign fe = (r_first == ST_OK) ? fin_code : r_first;

    always_comb begin
        n_state = r_state; n_end = r_end; n_count = r_count; n_msg_len = r_msg_len;
        n_phase = r_phase; n_esc_step = r_esc_step; n_esc_hi = r_esc_hi;
        n_key_len = r_key_len; n_val_len = r_val_len; n_last = r_last; n_flags = r_flags;
        n_first = r_first; n_raw_len = r_raw_len; n_index = r_index; n_val_esc = r_val_esc;
        n_enc = r_enc; n_code = r_code; n_i = r_i; n_j = r_j;
        n_o_valid = r_o_valid && !i_ready;
        n_o_kind = r_o_kind; n_o_byte = r_o_byte; n_o_field = r_o_field;
        n_o_status = r_o_status;
        vb = i_data_byte; emit_v = 1'b0; esc_sum = '0;

        kreq = '0;
        kreq.w_slot    = r_count[SlotBits-1:0];
        kreq.w_pos     = r_key_len[PosBits-1:0];
        kreq.w_byte    = i_data_byte;
        kreq.len_wdata = r_key_len;
        kreq.r_slot    = r_i[SlotBits-1:0];
        kreq.r_pos     = r_j[PosBits-1:0];

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (i_action) begin
                        if (r_msg_len == 18'd0) begin
                            n_o_valid = 1'b1; n_o_kind = KIND_STATUS; n_o_byte = 8'd0;
                            n_o_field = 7'd0; n_o_status = ST_EMPTY;
                        end else begin
                            n_end = 1'b1; n_state = S_CHK;
                        end
                    end else begin
                        if (r_msg_len != '1) n_msg_len = r_msg_len + 18'd1;
                        if (i_data_byte == ";") begin
                            n_end = 1'b0; n_state = S_CHK;
                        end else begin
                            if (r_raw_len != 2'd3) n_raw_len = r_raw_len + 2'd1;
                            if (i_data_byte == 8'h0a || i_data_byte == 8'h0d)
                                n_flags[FCrlf] = 1'b1;
                            if (!r_phase) begin
                                if (i_data_byte == "=") begin
                                    if (r_raw_len == 2'd0) n_flags[FEqFirst] = 1'b1;
                                    n_phase = 1'b1;
                                end else begin
                                    if (r_key_len == 8'd0 && i_data_byte == ".")
                                        n_flags[FKeyDot] = 1'b1;
                                    if (!key_char_ok(i_data_byte)) n_flags[FKeyChar] = 1'b1;
                                    if (r_key_len < 8'(MaxKeyBytes)) begin
                                        kreq.cur_we   = 1'b1;
                                        kreq.store_we = r_count < 9'(MaxFields);
                                    end
                                    if (r_key_len != '1) n_key_len = r_key_len + 8'd1;
                                    n_last = i_data_byte;
                                    n_o_valid = 1'b1; n_o_kind = KIND_KEY;
                                    n_o_byte = i_data_byte;
                                    n_o_field = r_index[7] ? 7'd127 : r_index[6:0];
                                    n_o_status = ST_OK;
                                end
                            end else begin
                                if (i_data_byte == "=") n_flags[FValEq] = 1'b1;
                                if (r_esc_step == 2'd0) begin
                                    if (i_data_byte == "%") n_esc_step = 2'd1;
                                    else emit_v = 1'b1;
                                end else if (!is_hex(i_data_byte)) begin
                                    n_flags[FEsc] = 1'b1; n_esc_step = 2'd0;
                                end else if (r_esc_step == 2'd1) begin
                                    n_esc_hi = hex_nibble(i_data_byte); n_esc_step = 2'd2;
                                end else begin
                                    n_esc_step = 2'd0; emit_v = 1'b1;
                                    vb = {r_esc_hi, hex_nibble(i_data_byte)};
                                end
                            end
                        end
                    end
                end
                if (emit_v) begin
                    if (r_val_len != '1) n_val_len = r_val_len + 17'd1;
                    if (vb == "%" || vb == ";" || vb == "=" || vb == "|" ||
                        vb == 8'h0a || vb == 8'h0d)
                        esc_sum = 19'(r_val_esc) + 19'd3;
                    else
                        esc_sum = 19'(r_val_esc) + 19'd1;
                    n_val_esc = esc_sum[18] ? '1 : esc_sum[17:0];
                    n_o_valid = 1'b1; n_o_kind = KIND_VALUE; n_o_byte = vb;
                    n_o_field = r_index[7] ? 7'd127 : r_index[6:0];
                    n_o_status = ST_OK;
                end
            end
            S_CHK: begin
                n_code = pre_code; n_i = 9'd0;
                n_state = (pre_code == ST_OK) ? S_LEN : S_FIN;
            end
            S_LEN: begin
                if (r_i == r_count) begin
                    n_code = ST_OK; n_state = S_FIN;
                end else begin
                    n_state = S_LCHK;
                end
            end
            S_LCHK: begin
                if (krsp.len != r_key_len) begin
                    n_i = r_i + 9'd1; n_state = S_LEN;
                end else if (r_key_len == 8'd0) begin
                    n_code = ST_DUP; n_state = S_FIN;
                end else begin
                    n_j = 8'd0; n_state = S_BYTE;
                end
            end
            S_BYTE: n_state = S_BCHK;
            S_BCHK: begin
                if (krsp.store_byte != krsp.cur_byte) begin
                    n_i = r_i + 9'd1; n_state = S_LEN;
                end else if (r_j + 8'd1 == r_key_len) begin
                    n_code = ST_DUP; n_state = S_FIN;
                end else begin
                    n_j = r_j + 8'd1; n_state = S_BYTE;
                end
            end
            S_FIN: begin
                if (!r_end || slot_free) begin
                    n_state = S_IDLE;
                    if (fin_code == ST_OK) begin
                        kreq.len_we = 1'b1;
                        n_count = r_count + 9'd1;
                        n_enc = enc_sum[16:0];
                    end
                    n_first = fe;
                    n_phase = 1'b0; n_esc_step = 2'd0; n_esc_hi = 4'd0; n_key_len = 8'd0;
                    n_val_len = 17'd0; n_last = 8'd0; n_flags = '0; n_raw_len = 2'd0;
                    n_val_esc = 18'd0;
                    if (r_end) begin
                        n_o_valid = 1'b1; n_o_kind = KIND_STATUS; n_o_byte = 8'd0;
                        n_o_field = 7'd0;
                        n_o_status = (r_msg_len > 18'(cfg.max_msg)) ? ST_TOO_LRG : fe;
                        n_count = 9'd0; n_msg_len = 18'd0; n_first = ST_OK;
                        n_index = 8'd0; n_enc = 17'd0;
                    end else if (r_index != '1) begin
                        n_index = r_index + 8'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_BYTE || r_state == S_BCHK) kreq.r_pos = r_j[PosBits-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_end <= 1'b0; r_count <= '0; r_msg_len <= '0;
            r_phase <= 1'b0; r_esc_step <= '0; r_esc_hi <= '0; r_key_len <= '0;
            r_val_len <= '0; r_last <= '0; r_flags <= '0; r_first <= ST_OK;
            r_raw_len <= '0; r_index <= '0; r_val_esc <= '0; r_enc <= '0;
            r_code <= ST_OK; r_i <= '0; r_j <= '0; r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_end <= n_end; r_count <= n_count; r_msg_len <= n_msg_len;
            r_phase <= n_phase; r_esc_step <= n_esc_step; r_esc_hi <= n_esc_hi;
            r_key_len <= n_key_len; r_val_len <= n_val_len; r_last <= n_last;
            r_flags <= n_flags; r_first <= n_first; r_raw_len <= n_raw_len;
            r_index <= n_index; r_val_esc <= n_val_esc; r_enc <= n_enc; r_code <= n_code;
            r_i <= n_i; r_j <= n_j; r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_kind <= n_o_kind; r_o_byte <= n_o_byte; r_o_field <= n_o_field;
        r_o_status <= n_o_status;
    end

    assign o_valid        = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_out_byte     = r_o_byte;
    assign o_field_number = r_o_field;
    assign o_status       = r_o_status;

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LCHK || r_state == S_BYTE || r_state == S_BCHK) |-> r_i < r_count)
        else $error("key walk past stored entries");
    a_byte_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_STATUS) |-> o_status == ST_OK)
        else $error("byte word carries a status");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 9'(MaxFields))
        else $error("stored entry count over limit");
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("ready during entry check");
endmodule
